// ===== design/pdvd_pkg.sv =====
// Shared types and constants for the postings delta varint decoder.
// No dependencies; imported by pdvd_step, the top level and the testbench.
package pdvd_pkg;

  // parse phase codes
  localparam logic [2:0] PhCount  = 3'd0;
  localparam logic [2:0] PhVarint = 3'd1;
  localparam logic [2:0] PhScore  = 3'd2;
  localparam logic [2:0] PhLength = 3'd3;
  localparam logic [2:0] PhId     = 3'd4;
  localparam logic [2:0] PhDone   = 3'd5;

  // slice status codes
  localparam logic [2:0] StRunning = 3'd0;
  localparam logic [2:0] StAllDone = 3'd1;
  localparam logic [2:0] StBetween = 3'd2;
  localparam logic [2:0] StMid     = 3'd3;
  localparam logic [2:0] StExtra   = 3'd4;

  // varint limits: 7 payload bits per byte, at most five bytes
  localparam logic [7:0] ContBit      = 8'h80;
  localparam logic [2:0] VarintLastIx = 3'd4;

  // widths of the output item
  localparam int unsigned OutDataW = 128;

  // parser state
  typedef struct packed {
    logic [2:0]  phase;
    logic [1:0]  field_byte_count;
    logic [31:0] entry_total;
    logic [31:0] entries_done;
    logic [31:0] running_hash;
    logic [31:0] varint_accum;
    logic [2:0]  varint_count;
    logic [31:0] score_accum;
    logic [15:0] length_accum;
    logic [15:0] id_remaining;
  } pdvd_state_t;

  localparam pdvd_state_t StateReset = '0;

  // one result item
  typedef struct packed {
    logic        id_byte_valid;
    logic [7:0]  id_byte;
    logic        entry_done;
    logic [31:0] doc_hash;
    logic [31:0] score_bits;
    logic [15:0] id_length;
    logic [31:0] entry_number;
    logic [2:0]  slice_status;
  } pdvd_result_t;

endpackage

// ===== design/pdvd_step.sv =====
// Combinational parse step: next parser state and result for one slice byte.
// Depends on pdvd_pkg.
module pdvd_step
  import pdvd_pkg::*;
(
  input  pdvd_state_t  state_i,
  input  logic [7:0]   byte_i,
  input  logic         last_i,
  output pdvd_state_t  state_o,
  output pdvd_result_t result_o
);

  pdvd_state_t  ns;
  pdvd_result_t res;
  logic         at_boundary;
  logic         vld;
  logic         done;
  logic [2:0]   status;
  logic [31:0]  o_hash;
  logic [31:0]  o_score;
  logic [15:0]  o_len;
  logic [31:0]  acc_new;
  logic [15:0]  len_new;
  logic [15:0]  rem_new;
  logic [31:0]  entries_next;
  logic [4:0]   vshift;
  logic         finish;

  // shift of the current varint byte
  always_comb begin
    unique case (state_i.varint_count)
      3'd0:    vshift = 5'd0;
      3'd1:    vshift = 5'd7;
      3'd2:    vshift = 5'd14;
      3'd3:    vshift = 5'd21;
      default: vshift = 5'd28;
    endcase
  end

  assign acc_new      = state_i.varint_accum | (32'(byte_i[6:0]) << vshift);
  assign len_new      = state_i.length_accum
                        | (16'(byte_i) << {state_i.field_byte_count[0], 3'b000});
  assign rem_new      = state_i.id_remaining - 16'(state_i.id_remaining != 16'd0);
  assign entries_next = state_i.entries_done + 32'd1;

  // phase logic
  always_comb begin
    ns          = state_i;
    at_boundary = 1'b0;
    vld         = 1'b0;
    done        = 1'b0;
    finish      = 1'b0;
    status      = StRunning;
    o_hash      = '0;
    o_score     = '0;
    o_len       = '0;
    unique case (state_i.phase)
      PhCount: begin
        ns.entry_total = state_i.entry_total
                         | (32'(byte_i) << {state_i.field_byte_count, 3'b000});
        if (state_i.field_byte_count == 2'd3) begin
          ns.field_byte_count = 2'd0;
          if (ns.entry_total == 32'd0) begin
            ns.phase = PhDone;
            status   = StAllDone;
          end else begin
            ns.phase        = PhVarint;
            ns.varint_accum = '0;
            ns.varint_count = '0;
            ns.score_accum  = '0;
            ns.length_accum = '0;
            ns.id_remaining = '0;
            at_boundary     = 1'b1;
          end
        end else begin
          ns.field_byte_count = state_i.field_byte_count + 2'd1;
        end
      end
      PhVarint: begin
        ns.varint_accum = acc_new;
        ns.varint_count = state_i.varint_count + 3'd1;
        if ((byte_i & ContBit) == 8'd0 || state_i.varint_count == VarintLastIx) begin
          ns.running_hash     = state_i.running_hash + acc_new;
          ns.phase            = PhScore;
          ns.field_byte_count = 2'd0;
        end
      end
      PhScore: begin
        ns.score_accum = state_i.score_accum
                         | (32'(byte_i) << {state_i.field_byte_count, 3'b000});
        if (state_i.field_byte_count == 2'd3) begin
          ns.field_byte_count = 2'd0;
          ns.phase            = PhLength;
        end else begin
          ns.field_byte_count = state_i.field_byte_count + 2'd1;
        end
      end
      PhLength: begin
        ns.length_accum = len_new;
        if (state_i.field_byte_count != 2'd0) begin
          ns.field_byte_count = 2'd0;
          if (len_new == 16'd0) begin
            done    = 1'b1;
            o_hash  = state_i.running_hash;
            o_score = state_i.score_accum;
            finish  = 1'b1;
          end else begin
            ns.id_remaining = len_new;
            ns.phase        = PhId;
          end
        end else begin
          ns.field_byte_count = state_i.field_byte_count + 2'd1;
        end
      end
      PhId: begin
        vld             = 1'b1;
        o_hash          = state_i.running_hash;
        o_score         = state_i.score_accum;
        o_len           = state_i.length_accum;
        ns.id_remaining = rem_new;
        if (rem_new == 16'd0) begin
          done   = 1'b1;
          finish = 1'b1;
        end
      end
      default: begin
        status = StExtra;
      end
    endcase

    // close the entry
    if (finish) begin
      ns.entries_done     = entries_next;
      ns.varint_accum     = '0;
      ns.varint_count     = '0;
      ns.score_accum      = '0;
      ns.length_accum     = '0;
      ns.id_remaining     = '0;
      ns.field_byte_count = '0;
      if (entries_next == state_i.entry_total) begin
        ns.phase = PhDone;
        status   = StAllDone;
      end else begin
        ns.phase    = PhVarint;
        at_boundary = 1'b1;
      end
    end

    // end of slice: report and start over
    if (last_i) begin
      if (status == StRunning) begin
        status = at_boundary ? StBetween : StMid;
      end
      ns = StateReset;
    end
  end

  // result item
  always_comb begin
    res               = '0;
    res.id_byte_valid = vld;
    res.id_byte       = vld ? byte_i : 8'd0;
    res.entry_done    = done;
    res.slice_status  = status;
    if (vld || done) begin
      res.doc_hash     = o_hash;
      res.score_bits   = o_score;
      res.id_length    = o_len;
      res.entry_number = state_i.entries_done;
    end
  end

  assign state_o  = ns;
  assign result_o = res;

endmodule

// ===== design/postings_delta_varint_decoder_core.sv =====
// Top level of the postings delta varint decoder: input register, parser state,
// result register and stream handshakes. Depends on pdvd_pkg and pdvd_step.
//
// Usage:
//   The slave stream carries one slice byte per item in s_axis_tdata, with
//   s_axis_tlast on the final byte of a slice. The master stream returns one
//   item per input byte: m_axis_tuser flags an id byte, m_axis_tlast flags
//   the byte that completes an entry, and m_axis_tdata carries the id byte,
//   doc hash, score bits, id length, entry number and slice status.
//   The byte waits in the input register, then passes the parse step into
//   the result register, which drives m_axis_tvalid.
//   Throughput is one byte per cycle while m_axis_tready stays high; the
//   parse state is updated in the same cycle that the input register hands
//   its byte on, so consecutive bytes flow without bubbles.
//   Reset clears the valid flags of both registers and returns the parser to
//   the count phase.
//   When the receiver holds m_axis_tready low, the result stays in place and
//   the input register fills; s_axis_tready drops only when both are full.
//   The last byte of a slice returns the parser to its reset state.
module postings_delta_varint_decoder_core
  import pdvd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] data_byte
  input  logic                s_axis_tlast,  // slice_end
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // [7:0] id_byte, [39:8] doc_hash,
                                             // [71:40] score_bits, [87:72] id_length,
                                             // [119:88] entry_number,
                                             // [122:120] slice_status, rest zero
  output logic                m_axis_tuser,  // id_byte_valid
  output logic                m_axis_tlast   // entry_done
);

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_last_q;
  logic         out_valid_q;
  pdvd_result_t out_q;
  pdvd_state_t  state_q;
  pdvd_state_t  state_d;
  pdvd_result_t result_d;
  logic         out_free;
  logic         advance;
  logic         in_take;

  // handshake control
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // parse step
  pdvd_step u_step (
    .state_i  (state_q),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result_d;
    end
  end

  // output packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.id_byte_valid;
  assign m_axis_tlast  = out_q.entry_done;
  assign m_axis_tdata  = {5'd0, out_q.slice_status, out_q.entry_number, out_q.id_length,
                          out_q.score_bits, out_q.doc_hash, out_q.id_byte};

  // no entry has finished while still counting
  a_count_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PhCount |-> state_q.entries_done == 32'd0)
    else $error("entries_done nonzero in count phase");

  // varint never runs past five bytes
  a_varint_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PhVarint |-> state_q.varint_count <= VarintLastIx)
    else $error("varint byte count overrun");

  // an id byte is never reported as ignored
  a_id_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> out_q.slice_status != StExtra)
    else $error("id byte with extra-byte status");

  // a completed entry is never reported as cut off
  a_done_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> out_q.slice_status != StMid
                                      && out_q.slice_status != StExtra)
    else $error("completed entry with mid-entry status");

  // the parser moves only when a byte leaves the input register
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("parser state changed without a byte");

endmodule

// ===== bench/postings_delta_varint_decoder_core_tb.sv =====
// Self-checking testbench for postings_delta_varint_decoder_core.
// Builds postings slices byte by byte, predicts every result item in step with
// the stream, and checks each result; depends on pdvd_pkg and the RTL only.
`timescale 1ns / 1ps

module postings_delta_varint_decoder_core_tb;
  import pdvd_pkg::*;

  localparam int unsigned RandomBytes   = 1450;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned AccumW        = 32;
  localparam int unsigned VarintStep    = 7;
  localparam int unsigned VarintMaxLen  = 5;

  typedef enum logic [1:0] {
    ReadyAlways,
    ReadyRandom,
    ReadyPeriodic,
    ReadySparse
  } ready_mode_e;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;  // [7:0] data_byte
  logic                s_axis_tlast  = 1'b0;  // slice_end
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;  // [7:0] id_byte, [39:8] doc_hash, [71:40] score_bits,
                                      // [87:72] id_length, [119:88] entry_number,
                                      // [122:120] slice_status
  logic                m_axis_tuser;  // id_byte_valid
  logic                m_axis_tlast;  // entry_done

  postings_delta_varint_decoder_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // decoder state as predicted by the bench
  logic [2:0]  phase_q;
  logic [1:0]  byte_ix;
  logic [31:0] count_total;
  logic [31:0] count_done;
  logic [31:0] doc_sum;
  logic [31:0] delta_acc;
  logic [5:0]  delta_shift;
  logic [31:0] score_acc;
  logic [15:0] len_acc;
  logic [15:0] id_left;

  pdvd_result_t decoded_q[$];
  logic [7:0]   slice_bytes[$];

  int unsigned error_count    = 0;
  int unsigned results_seen   = 0;
  int unsigned bytes_parsed   = 0;
  int unsigned slices_sent    = 0;
  int unsigned entries_seen   = 0;
  int unsigned cut_slices     = 0;
  int unsigned ignored_bytes  = 0;
  int unsigned burst_left     = 0;
  bit          steady         = 1'b0;
  int unsigned ready_tick     = 0;
  ready_mode_e ready_mode     = ReadyAlways;

  // per-entry fields cleared between entries
  task automatic clear_entry_fields();
    delta_acc   = '0;
    delta_shift = '0;
    score_acc   = '0;
    len_acc     = '0;
    id_left     = '0;
    byte_ix     = '0;
  endtask

  task automatic reset_prediction();
    phase_q     = PhCount;
    count_total = '0;
    count_done  = '0;
    doc_sum     = '0;
    clear_entry_fields();
  endtask

  // count one finished entry; either all done or back to the next delta
  task automatic close_entry(output logic [2:0] status, output logic boundary);
    count_done = count_done + 32'd1;
    clear_entry_fields();
    boundary = 1'b0;
    if (count_done == count_total) begin
      phase_q = PhDone;
      status  = StAllDone;
    end else begin
      phase_q  = PhVarint;
      status   = StRunning;
      boundary = 1'b1;
    end
  endtask

  // predict the result item caused by one slice byte
  task automatic decode_byte(input logic [7:0] b, input logic last);
    pdvd_result_t r;
    logic         boundary;
    logic [31:0]  index_now;
    r         = '0;
    boundary  = 1'b0;
    index_now = count_done;
    case (phase_q)
      PhCount: begin
        count_total = count_total | (32'(b) << (8 * byte_ix));
        if (byte_ix == 2'd3) begin
          byte_ix = '0;
          if (count_total == '0) begin
            phase_q        = PhDone;
            r.slice_status = StAllDone;
          end else begin
            phase_q = PhVarint;
            clear_entry_fields();
            boundary = 1'b1;
          end
        end else begin
          byte_ix = byte_ix + 2'd1;
        end
      end
      PhVarint: begin
        if (delta_shift < AccumW) delta_acc = delta_acc | (32'(b & ~ContBit) << delta_shift);
        delta_shift = delta_shift + 6'(VarintStep);
        if (((b & ContBit) == '0) || (delta_shift >= AccumW)) begin
          doc_sum = doc_sum + delta_acc;
          phase_q = PhScore;
          byte_ix = '0;
        end
      end
      PhScore: begin
        score_acc = score_acc | (32'(b) << (8 * byte_ix));
        if (byte_ix == 2'd3) begin
          byte_ix = '0;
          phase_q = PhLength;
        end else begin
          byte_ix = byte_ix + 2'd1;
        end
      end
      PhLength: begin
        len_acc = len_acc | (16'(b) << (8 * byte_ix[0]));
        if (byte_ix != '0) begin
          byte_ix = '0;
          if (len_acc == '0) begin
            r.entry_done = 1'b1;
            r.doc_hash   = doc_sum;
            r.score_bits = score_acc;
            close_entry(r.slice_status, boundary);
          end else begin
            id_left = len_acc;
            phase_q = PhId;
          end
        end else begin
          byte_ix = byte_ix + 2'd1;
        end
      end
      PhId: begin
        r.id_byte_valid = 1'b1;
        r.id_byte       = b;
        r.doc_hash      = doc_sum;
        r.score_bits    = score_acc;
        r.id_length     = len_acc;
        if (id_left != '0) id_left = id_left - 16'd1;
        if (id_left == '0) begin
          r.entry_done = 1'b1;
          close_entry(r.slice_status, boundary);
        end
      end
      default: r.slice_status = StExtra;
    endcase

    // slice end: settle the status and start over
    if (last) begin
      if (r.slice_status == StRunning) r.slice_status = boundary ? StBetween : StMid;
      reset_prediction();
    end
    if (r.id_byte_valid || r.entry_done) r.entry_number = index_now;
    if (r.slice_status != StExtra) bytes_parsed++;
    decoded_q.insert(decoded_q.size(), r);
  endtask

  // drive one byte, wait for it to be taken, then maybe pause the sender
  task automatic send_byte(input logic [7:0] b, input logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_byte(b, last);
    if (!steady) begin
      if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_slice();
    steady = ($urandom_range(0, 3) == 0);
    foreach (slice_bytes[i]) send_byte(slice_bytes[i], i == slice_bytes.size() - 1);
    slice_bytes.delete();
    slices_sent++;
  endtask

  // slice builders
  function automatic void add_byte(input logic [7:0] b);
    slice_bytes.insert(slice_bytes.size(), b);
  endfunction

  function automatic void put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) add_byte(v[8*i +: 8]);
  endfunction

  // leb128 in nbytes groups, possibly padded beyond the minimal length
  function automatic void put_varint(input logic [31:0] v, input bit padded);
    int n;
    logic [7:0] group;
    n = 1;
    while (n < VarintMaxLen && (v >> (VarintStep * n)) != '0) n++;
    if (padded) n = n + $urandom_range(0, VarintMaxLen - n);
    for (int i = 0; i < n; i++) begin
      group = 8'((v >> (VarintStep * i))) & ~ContBit;
      if (i != n - 1) group = group | ContBit;
      add_byte(group);
    end
  endfunction

  // five bytes with continuation set on the first four, random fifth
  function automatic void put_overlong();
    for (int i = 0; i < VarintMaxLen - 1; i++) begin
      add_byte(ContBit | 8'($urandom_range(0, 127)));
    end
    add_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic logic [31:0] pick_delta();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 127);
      1: return $urandom_range(128, 1 << 21);
      2: return $urandom();
      default: return 32'hFFFF_FFFF - $urandom_range(0, 3);
    endcase
  endfunction

  function automatic void put_entry(input logic [15:0] len, input int ids);
    if ($urandom_range(0, 7) == 0) put_overlong();
    else put_varint(pick_delta(), $urandom_range(0, 5) == 0);
    put_le($urandom(), 4);
    put_le(32'(len), 2);
    for (int i = 0; i < ids; i++) add_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic logic [15:0] pick_length();
    return ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
  endfunction

  // directed tests
  task automatic test_zero_count();
    put_le(32'd0, 4);
    add_byte(8'hAA);
    send_slice();
  endtask

  task automatic test_cut_in_count();
    add_byte(8'h03);
    send_slice();
  endtask

  task automatic test_cut_after_count();
    put_le(32'hFFFF_FFFF, 4);
    send_slice();
  endtask

  // all-ones overlong delta, zero id length, slice ends between entries
  task automatic test_overlong_zero_length();
    put_le(32'd2, 4);
    repeat (VarintMaxLen) add_byte(8'hFF);
    put_le(32'h8000_0000, 4);
    put_le(32'd0, 2);
    send_slice();
  endtask

  // two-byte delta, two id bytes, then one ignored trailing byte
  task automatic test_full_entry();
    put_le(32'd1, 4);
    add_byte(8'h81);
    add_byte(8'h01);
    put_le(32'h3F80_0000, 4);
    put_le(32'd2, 2);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h5A);
    send_slice();
  endtask

  // maximum id length, slice ends on the first id byte
  task automatic test_cut_in_id();
    put_le(32'd1, 4);
    add_byte(8'h00);
    put_le(32'hFFFF_FFFF, 4);
    put_le(32'hFFFF, 2);
    add_byte(8'hA5);
    send_slice();
  endtask

  // mostly well-formed slices with random content, some cut short or junk
  task automatic test_random_slices();
    int unsigned goal;
    int unsigned kind;
    int unsigned n;
    int unsigned cut;
    logic [15:0] len;
    goal = bytes_parsed + RandomBytes;
    while (bytes_parsed < goal) begin
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        repeat ($urandom_range(1, 24)) add_byte(8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, 4);
        put_le(n, 4);
        for (int i = 0; i < n - 1; i++) begin
          len = pick_length();
          put_entry(len, len);
        end
        if (kind == 8) begin
          // long id length, slice ends before the id is through
          put_entry(16'($urandom_range(7, 65535)), $urandom_range(0, 3));
        end else begin
          len = pick_length();
          put_entry(len, len);
          repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
          if (kind >= 6) begin
            cut = $urandom_range(1, slice_bytes.size() - 1);
            while (slice_bytes.size() > cut) void'(slice_bytes.pop_back());
          end
        end
      end
      send_slice();
    end
  endtask

  // receiver readiness follows a randomly chosen mode: always, random, periodic or sparse
  always @(posedge clk_i) begin
    if (ready_tick % 96 == 0) ready_mode = ready_mode_e'($urandom_range(0, 3));
    case (ready_mode)
      ReadyAlways:   m_axis_tready <= 1'b1;
      ReadyRandom:   m_axis_tready <= ($urandom_range(0, 2) != 0);
      ReadyPeriodic: m_axis_tready <= ((ready_tick % 8) < 5);
      default:       m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
    ready_tick++;
  end

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t ns: %s mismatch on result %0d: expected %0h actual %0h",
               $time, name, results_seen, want, got);
    end
  endtask

  // compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    pdvd_result_t got;
    pdvd_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.id_byte_valid = m_axis_tuser;
      got.entry_done    = m_axis_tlast;
      got.id_byte       = m_axis_tdata[7:0];
      got.doc_hash      = m_axis_tdata[39:8];
      got.score_bits    = m_axis_tdata[71:40];
      got.id_length     = m_axis_tdata[87:72];
      got.entry_number  = m_axis_tdata[119:88];
      got.slice_status  = m_axis_tdata[122:120];
      if (decoded_q.size() == 0) begin
        error_count++;
        $display("%0t ns: result with no prediction waiting, tdata %0h", $time, m_axis_tdata);
      end else begin
        want = decoded_q.pop_front();
        report_field("id_byte_valid", 32'(want.id_byte_valid), 32'(got.id_byte_valid));
        report_field("id_byte", 32'(want.id_byte), 32'(got.id_byte));
        report_field("entry_done", 32'(want.entry_done), 32'(got.entry_done));
        report_field("doc_hash", want.doc_hash, got.doc_hash);
        report_field("score_bits", want.score_bits, got.score_bits);
        report_field("id_length", 32'(want.id_length), 32'(got.id_length));
        report_field("entry_number", want.entry_number, got.entry_number);
        report_field("slice_status", 32'(want.slice_status), 32'(got.slice_status));
        report_field("tdata padding", '0, 32'(m_axis_tdata[OutDataW-1:123]));
        if (want.entry_done) entries_seen++;
        if (want.slice_status == StMid) cut_slices++;
        if (want.slice_status == StExtra) ignored_bytes++;
      end
      results_seen++;
    end
  end

  // end the run when nothing moves on either side for too long
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t ns: no item moved for %0d cycles, %0d predictions outstanding",
             $time, WatchdogLimit, decoded_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // test sequence
  initial begin
    reset_prediction();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_count();
    test_cut_in_count();
    test_cut_after_count();
    test_overlong_zero_length();
    test_full_entry();
    test_cut_in_id();
    test_random_slices();
    s_axis_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("run covered %0d parsed bytes in %0d slices with %0d results checked",
             bytes_parsed, slices_sent, results_seen);
    $display("entries completed %0d, slices cut mid-entry %0d, trailing bytes ignored %0d",
             entries_seen, cut_slices, ignored_bytes);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", error_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
